// ----- rtl/lpfw_pkg.sv -----
// Shared types and constants for the lidar point frame windowing block.
// Depends on nothing; the files that use it refer to it by scoped names.
package lpfw_pkg;

    localparam int unsigned BATCH_POINTS_MAX_DEF = 65536;
    localparam logic [31:0] PERIOD_RESET         = 32'd100000000;
    localparam int unsigned SCALED_W             = 39;
    localparam int unsigned NUM_W                = 56;
    localparam int unsigned QDEPTH               = 2;
    localparam logic        CMD_POINT            = 1'b0;
    localparam logic        CMD_RESET            = 1'b1;

    typedef enum logic [1:0] {
        KIND_POINT   = 2'd0,
        KIND_CLOSED  = 2'd1,
        KIND_DISCARD = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef struct packed {
        logic        command;
        logic [15:0] pt_index;
        logic [16:0] batch_size;
        logic [31:0] interval_100ns;
        logic [63:0] batch_timestamp_ns;
        logic [31:0] source_id;
        logic [63:0] batch_timestamp_raw;
        logic [63:0] point_payload;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic        last;
        logic [63:0] frame_timestamp_ns;
        logic [31:0] frame_source_id;
        logic [63:0] frame_timestamp_raw;
        logic [31:0] point_offset_ns;
        logic [63:0] out_payload;
        logic [31:0] frame_interval_100ns;
        logic [31:0] frame_point_count;
    } t_result;

    // A classified point or reset command travelling from the front end to the frame engine.
    typedef struct packed {
        logic        command;
        logic        overflow;
        logic [63:0] point_time;
        logic [31:0] source_id;
        logic [63:0] batch_timestamp_raw;
        logic [63:0] point_payload;
    } t_task;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SCALE,
        F_MUL,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EVAL,
        B_DIV,
        B_OUT_PRE,
        B_OUT_PT
    } t_back_state;

endpackage

// ----- rtl/lpfw_fifo.sv -----
// Small register queue used between the block's stages and at its output.
// Generic width and depth; no package dependency.
module lpfw_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/lpfw_divider.sv -----
// Iterative unsigned divider, four quotient bits per cycle.
// Generic widths; no package dependency.
module lpfw_divider #(
    parameter int unsigned DW = 56,
    parameter int unsigned VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    localparam int unsigned NS = (DW + 3) / 4;
    localparam int unsigned PW = NS * 4;
    localparam int unsigned CW = $clog2(NS + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_num;
    logic [PW-1:0] r_quot;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [PW-1:0] w_num;
    logic [PW-1:0] w_quot;
    logic [VW-1:0] w_rem;

    always_comb begin
        logic [VW:0] wide;
        w_num  = r_num;
        w_quot = r_quot;
        w_rem  = r_rem;
        for (int k = 0; k < 4; k++) begin
            wide  = {w_rem, w_num[PW-1]};
            w_num = {w_num[PW-2:0], 1'b0};
            if (wide >= {1'b0, r_div}) begin
                wide   = wide - {1'b0, r_div};
                w_quot = {w_quot[PW-2:0], 1'b1};
            end else begin
                w_quot = {w_quot[PW-2:0], 1'b0};
            end
            w_rem = wide[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(NS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= PW'(i_dividend);
            r_quot <= '0;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_num  <= w_num;
            r_quot <= w_quot;
            r_rem  <= w_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot[DW-1:0];
    assign o_rem  = r_rem;

endmodule

// ----- rtl/lpfw_front.sv -----
// Front end: accepts input beats, spreads the batch span over the batch and
// forms each point's timestamp. Depends on lpfw_pkg and lpfw_divider.
module lpfw_front #(
    parameter int unsigned BATCH_POINTS_MAX = lpfw_pkg::BATCH_POINTS_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpfw_pkg::t_item i_item,
    input  logic            i_push,
    output logic            o_full,
    output lpfw_pkg::t_task o_task,
    output logic            o_task_push,
    input  logic            i_task_full
);

    localparam int unsigned GW = $clog2(BATCH_POINTS_MAX);
    localparam int unsigned NW = lpfw_pkg::NUM_W;
    localparam int unsigned SW = lpfw_pkg::SCALED_W;

    lpfw_pkg::t_front_state r_state;
    lpfw_pkg::t_front_state n_state;
    lpfw_pkg::t_item        r_item;
    logic [SW-1:0]          r_scaled;
    logic [GW-1:0]          r_gaps;
    logic                   r_short;
    logic [NW-1:0]          r_off;
    logic [31:0]            w_cnt;
    logic [31:0]            w_cnt_c;
    logic [NW-1:0]          w_num;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [NW-1:0]          w_quot;
    logic [63:0]            w_off;

    assign w_cnt   = 32'(r_item.batch_size);
    assign w_cnt_c = (w_cnt > 32'(BATCH_POINTS_MAX)) ? 32'(BATCH_POINTS_MAX) : w_cnt;
    // Rounded to nearest: half the gap count is added before the division.
    assign w_num   = NW'(r_item.pt_index) * NW'(r_scaled) + NW'(r_gaps >> 1);
    assign w_off   = 64'(r_off);

    lpfw_divider #(
        .DW(NW),
        .VW(GW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_num),
        .i_divisor (r_gaps),
        .o_busy    (),
        .o_done    (w_div_done),
        .o_quot    (w_quot),
        .o_rem     ()
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            lpfw_pkg::F_IDLE: begin
                if (i_push) n_state = lpfw_pkg::F_SCALE;
            end
            lpfw_pkg::F_SCALE: begin
                if (r_item.command == lpfw_pkg::CMD_RESET) n_state = lpfw_pkg::F_PUSH;
                else n_state = lpfw_pkg::F_MUL;
            end
            lpfw_pkg::F_MUL: begin
                n_state = r_short ? lpfw_pkg::F_PUSH : lpfw_pkg::F_DIV;
            end
            lpfw_pkg::F_DIV: begin
                if (w_div_done) n_state = lpfw_pkg::F_PUSH;
            end
            lpfw_pkg::F_PUSH: begin
                if (!i_task_full) n_state = lpfw_pkg::F_IDLE;
            end
            default: n_state = lpfw_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_full      = (r_state != lpfw_pkg::F_IDLE);
        w_div_start = (r_state == lpfw_pkg::F_MUL) && !r_short;
        o_task_push = (r_state == lpfw_pkg::F_PUSH) && !i_task_full;
        o_task.command             = r_item.command;
        o_task.overflow            = (r_item.command == lpfw_pkg::CMD_POINT)
                                     && (r_item.batch_timestamp_ns > (~64'd0 - w_off));
        o_task.point_time          = r_item.batch_timestamp_ns + w_off;
        o_task.source_id           = r_item.source_id;
        o_task.batch_timestamp_raw = r_item.batch_timestamp_raw;
        o_task.point_payload       = r_item.point_payload;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpfw_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lpfw_pkg::F_IDLE: begin
                if (i_push) r_item <= i_item;
            end
            lpfw_pkg::F_SCALE: begin
                r_scaled <= SW'(r_item.interval_100ns) * SW'(100);
                r_gaps   <= GW'(w_cnt_c - 32'd1);
                r_short  <= (w_cnt_c <= 32'd1) || (r_item.interval_100ns == 32'd0);
                r_off    <= '0;
            end
            lpfw_pkg::F_DIV: begin
                if (w_div_done) r_off <= w_quot;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/lpfw_back.sv -----
// Frame engine: holds the window state, decides discard, close and point
// records, and writes them to the result queue. Depends on lpfw_pkg, lpfw_divider.
module lpfw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpfw_pkg::t_task   i_task,
    input  logic              i_task_empty,
    output logic              o_task_pop,
    input  logic [31:0]       i_period,
    output lpfw_pkg::t_result o_res,
    output logic              o_res_push,
    input  logic              i_res_full
);

    localparam logic [33:0] RECIP_100 = 34'd10995116278;

    lpfw_pkg::t_back_state r_state;
    lpfw_pkg::t_back_state n_state;
    lpfw_pkg::t_task       r_task;
    lpfw_pkg::t_result     r_pre;
    lpfw_pkg::t_result     r_pt;
    logic                  r_have_pre;
    lpfw_pkg::t_result     n_pre;
    lpfw_pkg::t_result     n_pt;
    logic                  n_have_pre;

    logic        r_active;
    logic [63:0] r_start;
    logic [63:0] r_end;
    logic [63:0] r_first;
    logic [31:0] r_open_id;
    logic [63:0] r_open_raw;
    logic [31:0] r_pending;
    logic [31:0] r_last_off;
    logic        n_commit;
    logic        n_clear;
    logic [63:0] n_start;
    logic [63:0] n_first;
    logic [31:0] n_pending;
    logic [31:0] n_last_off;

    logic [31:0] w_p32;
    logic [63:0] w_p;
    logic [63:0] w_t;
    logic        w_back;
    logic        w_eff;
    logic        w_open_ovf;
    logic        w_cross;
    logic        w_div_start;
    logic        w_div_done;
    logic [31:0] w_rem;
    logic [63:0] w_ws;
    logic        w_ws_ovf;
    logic [66:0] w_ceil_prod;
    lpfw_pkg::t_result w_frame;

    assign w_p32      = (i_period == 32'd0) ? 32'd1 : i_period;
    assign w_p        = 64'(w_p32);
    assign w_t        = r_task.point_time;
    assign w_back     = r_active && (w_t < r_start);
    assign w_eff      = r_active && !w_back;
    assign w_open_ovf = w_t > (~64'd0 - w_p);
    assign w_cross    = w_eff && (w_t >= r_end);
    assign w_ws       = w_t - 64'(w_rem);
    assign w_ws_ovf   = w_ws > (~64'd0 - w_p);
    // Ceiling of the last offset over 100, by a reciprocal that is exact here.
    assign w_ceil_prod = 67'(33'(r_last_off) + 33'd99) * 67'(RECIP_100);

    lpfw_divider #(
        .DW(64),
        .VW(32)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_t - r_start),
        .i_divisor (w_p32),
        .o_busy    (),
        .o_done    (w_div_done),
        .o_quot    (),
        .o_rem     (w_rem)
    );

    always_comb begin
        w_frame                      = '0;
        w_frame.frame_timestamp_ns   = r_first;
        w_frame.frame_source_id      = r_open_id;
        w_frame.frame_timestamp_raw  = r_open_raw;
        w_frame.frame_point_count    = r_pending;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lpfw_pkg::B_IDLE: begin
                if (!i_task_empty) n_state = lpfw_pkg::B_EVAL;
            end
            lpfw_pkg::B_EVAL: begin
                if (r_task.command == lpfw_pkg::CMD_POINT && !r_task.overflow && w_cross) begin
                    n_state = lpfw_pkg::B_DIV;
                end else begin
                    n_state = lpfw_pkg::B_OUT_PRE;
                end
            end
            lpfw_pkg::B_DIV: begin
                if (w_div_done) n_state = lpfw_pkg::B_OUT_PRE;
            end
            lpfw_pkg::B_OUT_PRE: begin
                if (!r_have_pre || !i_res_full) n_state = lpfw_pkg::B_OUT_PT;
            end
            lpfw_pkg::B_OUT_PT: begin
                if (!i_res_full) n_state = lpfw_pkg::B_IDLE;
            end
            default: n_state = lpfw_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_task_pop  = (r_state == lpfw_pkg::B_IDLE) && !i_task_empty;
        w_div_start = 1'b0;
        o_res_push  = 1'b0;
        o_res       = r_pt;
        n_pre       = r_pre;
        n_pt        = r_pt;
        n_have_pre  = r_have_pre;
        n_commit    = 1'b0;
        n_clear     = 1'b0;
        n_start     = w_t;
        n_first     = w_t;
        n_pending   = 32'd1;
        n_last_off  = 32'd0;

        case (r_state)
            lpfw_pkg::B_EVAL: begin
                n_have_pre = 1'b0;
                n_pt       = '0;
                n_pt.kind  = lpfw_pkg::KIND_ERROR;
                n_pt.last  = 1'b1;
                if (r_task.command == lpfw_pkg::CMD_RESET) begin
                    n_pt      = w_frame;
                    n_pt.kind = lpfw_pkg::KIND_DISCARD;
                    n_pt.last = 1'b1;
                    n_clear   = 1'b1;
                end else if (r_task.overflow || (!w_eff && w_open_ovf)) begin
                    n_have_pre = 1'b0;
                end else if (w_cross) begin
                    w_div_start = 1'b1;
                end else begin
                    // Either a new frame opens at the point (after a discard when
                    // time went backward) or the point joins the open frame.
                    n_commit = 1'b1;
                    if (w_eff) begin
                        n_start    = r_start;
                        n_first    = r_first;
                        n_pending  = (r_pending == ~32'd0) ? r_pending : r_pending + 32'd1;
                        n_last_off = 32'(w_t - r_first);
                    end
                    n_have_pre     = w_back;
                    n_pre          = w_frame;
                    n_pre.kind     = lpfw_pkg::KIND_DISCARD;
                end
            end
            lpfw_pkg::B_DIV: begin
                if (w_div_done) begin
                    n_pt       = '0;
                    n_pt.kind  = lpfw_pkg::KIND_ERROR;
                    n_pt.last  = 1'b1;
                    n_have_pre = 1'b0;
                    if (!w_ws_ovf) begin
                        n_commit   = 1'b1;
                        n_start    = w_ws;
                        n_have_pre = (r_pending != 32'd0);
                        n_pre      = w_frame;
                        n_pre.kind = lpfw_pkg::KIND_CLOSED;
                        n_pre.frame_interval_100ns = 32'(w_ceil_prod[66:40]);
                    end
                end
            end
            lpfw_pkg::B_OUT_PRE: begin
                o_res      = r_pre;
                o_res_push = r_have_pre;
            end
            lpfw_pkg::B_OUT_PT: begin
                o_res_push = 1'b1;
            end
            default: begin
            end
        endcase

        if (n_commit) begin
            n_pt                     = '0;
            n_pt.kind                = lpfw_pkg::KIND_POINT;
            n_pt.last                = 1'b1;
            n_pt.frame_timestamp_ns  = n_first;
            n_pt.frame_source_id     = (n_first == r_first && n_start == r_start && w_eff
                                        && !w_cross) ? r_open_id : r_task.source_id;
            n_pt.frame_timestamp_raw = (n_first == r_first && n_start == r_start && w_eff
                                        && !w_cross) ? r_open_raw : r_task.batch_timestamp_raw;
            n_pt.point_offset_ns     = n_last_off;
            n_pt.out_payload         = r_task.point_payload;
            n_pt.frame_point_count   = n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lpfw_pkg::B_IDLE;
            r_have_pre <= 1'b0;
            r_active   <= 1'b0;
            r_start    <= '0;
            r_end      <= '0;
            r_first    <= '0;
            r_open_id  <= '0;
            r_open_raw <= '0;
            r_pending  <= '0;
            r_last_off <= '0;
        end else begin
            r_state    <= n_state;
            r_have_pre <= n_have_pre;
            if (n_clear) begin
                r_active   <= 1'b0;
                r_start    <= '0;
                r_end      <= '0;
                r_first    <= '0;
                r_open_id  <= '0;
                r_open_raw <= '0;
                r_pending  <= '0;
                r_last_off <= '0;
            end else if (n_commit) begin
                r_active   <= 1'b1;
                r_start    <= n_start;
                r_first    <= n_first;
                r_pending  <= n_pending;
                r_last_off <= n_last_off;
                if (!(w_eff && !w_cross)) begin
                    r_end      <= n_start + w_p;
                    r_open_id  <= r_task.source_id;
                    r_open_raw <= r_task.batch_timestamp_raw;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_task_pop) r_task <= i_task;
        r_pre <= n_pre;
        r_pt  <= n_pt;
    end

    a_idle_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_pending == 32'd0 && r_end == 64'd0))
        else $error("closed frame state is not cleared");
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_end > r_start))
        else $error("window end does not follow window start");
    a_open_has_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_pending != 32'd0))
        else $error("open frame holds no point");

endmodule

// ----- rtl/lidar_point_frame_windowing.sv -----
// Top level of the lidar point frame windowing block.
// Depends on lpfw_pkg, lpfw_fifo, lpfw_front and lpfw_back.
//
// Points and reset commands enter through a queue-style push/full port and
// results leave through empty/pop, oldest first; a point yields one or two
// result beats, with last set on the final one. The front end takes one beat
// at a time and spreads the batch span by its divider, four quotient bits per
// cycle, but not for a point whose batch is too short or has a zero interval,
// or for a reset command. The frame engine sits behind a two-entry queue;
// where a point crosses a window end, a second four-bit-per-cycle divider
// aligns the new window. The period register may be written only while the
// block is idle; its write port is always ready.
module lidar_point_frame_windowing #(
    parameter int unsigned BATCH_POINTS_MAX = lpfw_pkg::BATCH_POINTS_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpfw_pkg::t_item   i_item,
    input  logic              push,
    output logic              full,
    output lpfw_pkg::t_result o_result,
    output logic              empty,
    input  logic              pop,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [31:0]       i_cfg_data
);

    localparam int unsigned TW = $bits(lpfw_pkg::t_task);
    localparam int unsigned RW = $bits(lpfw_pkg::t_result);

    logic [31:0]       r_period;
    lpfw_pkg::t_task   w_task_in;
    logic              w_task_push;
    logic              w_task_full;
    logic [TW-1:0]     w_task_bits;
    logic              w_task_empty;
    logic              w_task_pop;
    lpfw_pkg::t_result w_res_in;
    logic              w_res_push;
    logic              w_res_full;
    logic [RW-1:0]     w_res_bits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= lpfw_pkg::PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_data;
        end
    end

    lpfw_front #(
        .BATCH_POINTS_MAX(BATCH_POINTS_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_push     (push),
        .o_full     (full),
        .o_task     (w_task_in),
        .o_task_push(w_task_push),
        .i_task_full(w_task_full)
    );

    lpfw_fifo #(
        .WIDTH(TW),
        .DEPTH(lpfw_pkg::QDEPTH)
    ) u_task_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_task_push),
        .i_data (w_task_in),
        .o_full (w_task_full),
        .i_pop  (w_task_pop),
        .o_data (w_task_bits),
        .o_empty(w_task_empty)
    );

    lpfw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_task      (lpfw_pkg::t_task'(w_task_bits)),
        .i_task_empty(w_task_empty),
        .o_task_pop  (w_task_pop),
        .i_period    (r_period),
        .o_res       (w_res_in),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full)
    );

    lpfw_fifo #(
        .WIDTH(RW),
        .DEPTH(lpfw_pkg::QDEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res_in),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_res_bits),
        .o_empty(empty)
    );

    assign o_result = lpfw_pkg::t_result'(w_res_bits);

endmodule

// ----- tb/tb_lidar_point_frame_windowing.sv -----
// Testbench for the lidar point frame windowing block: directed and random points,
// reset commands and period settings, checked against an in-bench frame predictor.
// Depends on lpfw_pkg and lidar_point_frame_windowing.
`timescale 1ns / 1ps

module tb_lidar_point_frame_windowing;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam logic [63:0] U64_TOP = 64'hFFFF_FFFF_FFFF_FFFF;

    logic              i_clk;
    logic              i_rst_n;
    lpfw_pkg::t_item   i_item;
    logic              push;
    logic              full;
    lpfw_pkg::t_result o_result;
    logic              empty;
    logic              pop;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [31:0]       i_cfg_data;

    lidar_point_frame_windowing uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .push(push), .full(full),
        .o_result(o_result), .empty(empty), .pop(pop), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Predictor state.
    logic        fr_active;
    logic [63:0] fr_win_start, fr_win_end, fr_first_time, fr_open_raw;
    logic [31:0] fr_open_id, fr_pending, fr_last_off, period_reg;

    lpfw_pkg::t_result expected_results[$];
    int unsigned mismatches, results_seen, items_sent, cycles;
    int unsigned hold_off_cycles;
    bit          draining;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic add_expected(input lpfw_pkg::t_result r);
        expected_results = {expected_results, r};
    endtask

    function automatic lpfw_pkg::t_result frame_record(input lpfw_pkg::t_kind k);
        lpfw_pkg::t_result r;
        r = '0;
        r.kind = k;
        r.frame_timestamp_ns = fr_first_time;
        r.frame_source_id = fr_open_id;
        r.frame_timestamp_raw = fr_open_raw;
        r.frame_point_count = fr_pending;
        return r;
    endfunction

    // Computes the results of one item; all but an error item advance the frame state.
    task automatic predict_frames(input lpfw_pkg::t_item it);
        logic [63:0] off, t, p, ws, cnt;
        logic [127:0] num;
        logic        s_active;
        logic [63:0] s_start, s_end, s_first, s_raw;
        logic [31:0] s_id, s_pend, s_loff;
        lpfw_pkg::t_result pre, r;
        bit have_pre, ovf;
        have_pre = 0;
        ovf = 0;
        pre = '0;
        if (it.command == lpfw_pkg::CMD_RESET) begin
            r = frame_record(lpfw_pkg::KIND_DISCARD);
            r.last = 1'b1;
            add_expected(r);
            fr_active = 0; fr_win_start = 0; fr_win_end = 0; fr_first_time = 0;
            fr_open_raw = 0; fr_open_id = 0; fr_pending = 0; fr_last_off = 0;
            return;
        end
        cnt = 64'(it.batch_size);
        if (cnt > 64'(lpfw_pkg::BATCH_POINTS_MAX_DEF)) cnt = 64'(lpfw_pkg::BATCH_POINTS_MAX_DEF);
        if (cnt <= 1 || it.interval_100ns == 0) off = 0;
        else begin
            num = 128'(it.pt_index) * (128'(it.interval_100ns) * 128'd100)
                  + 128'((cnt - 64'd1) / 64'd2);
            off = 64'(num / 128'(cnt - 64'd1));
        end
        p = (period_reg == 0) ? 64'd1 : {32'd0, period_reg};
        s_active = fr_active; s_start = fr_win_start; s_end = fr_win_end;
        s_first = fr_first_time; s_raw = fr_open_raw; s_id = fr_open_id;
        s_pend = fr_pending; s_loff = fr_last_off;
        t = it.batch_timestamp_ns + off;
        if (it.batch_timestamp_ns > U64_TOP - off) ovf = 1;
        else begin
            if (s_active && t < s_start) begin
                pre = frame_record(lpfw_pkg::KIND_DISCARD);
                have_pre = 1;
                s_active = 0; s_start = 0; s_end = 0; s_pend = 0; s_loff = 0;
            end
            if (!s_active) begin
                if (t > U64_TOP - p) ovf = 1;
                else begin
                    s_active = 1; s_start = t; s_end = t + p; s_first = t;
                    s_id = it.source_id; s_raw = it.batch_timestamp_raw;
                    s_pend = 0; s_loff = 0;
                end
            end
            if (!ovf && t >= s_end) begin
                if (s_pend != 0) begin
                    pre = '0;
                    pre.kind = lpfw_pkg::KIND_CLOSED;
                    pre.frame_timestamp_ns = s_first;
                    pre.frame_source_id = s_id;
                    pre.frame_timestamp_raw = s_raw;
                    pre.frame_point_count = s_pend;
                    pre.frame_interval_100ns = 32'((64'(s_loff) + 64'd99) / 64'd100);
                    have_pre = 1;
                end
                ws = s_start + ((t - s_start) / p) * p;
                if (ws > U64_TOP - p) ovf = 1;
                else begin
                    s_start = ws; s_end = ws + p; s_first = t;
                    s_id = it.source_id; s_raw = it.batch_timestamp_raw;
                    s_pend = 0; s_loff = 0;
                end
            end
        end
        if (ovf) begin
            r = '0;
            r.kind = lpfw_pkg::KIND_ERROR;
            r.last = 1'b1;
            add_expected(r);
            return;
        end
        s_loff = 32'(t - s_first);
        if (s_pend != 32'hFFFF_FFFF) s_pend++;
        fr_active = s_active; fr_win_start = s_start; fr_win_end = s_end;
        fr_first_time = s_first; fr_open_raw = s_raw; fr_open_id = s_id;
        fr_pending = s_pend; fr_last_off = s_loff;
        if (have_pre) add_expected(pre);
        r = frame_record(lpfw_pkg::KIND_POINT);
        r.last = 1'b1;
        r.point_offset_ns = s_loff;
        r.out_payload = it.point_payload;
        add_expected(r);
    endtask

    function automatic int unsigned random_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: pops at random or, when draining, always; waits out hold_off_cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                lpfw_pkg::t_result w;
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result kind", 64'(o_result.kind), 64'd0);
                end else begin
                    w = expected_results.pop_front();
                    if (o_result.kind != w.kind)
                        report_mismatch("kind", 64'(o_result.kind), 64'(w.kind));
                    if (o_result.last != w.last)
                        report_mismatch("last", 64'(o_result.last), 64'(w.last));
                    if (o_result.frame_timestamp_ns != w.frame_timestamp_ns)
                        report_mismatch("frame_timestamp_ns", o_result.frame_timestamp_ns,
                                        w.frame_timestamp_ns);
                    if (o_result.frame_source_id != w.frame_source_id)
                        report_mismatch("frame_source_id", 64'(o_result.frame_source_id),
                                        64'(w.frame_source_id));
                    if (o_result.frame_timestamp_raw != w.frame_timestamp_raw)
                        report_mismatch("frame_timestamp_raw", o_result.frame_timestamp_raw,
                                        w.frame_timestamp_raw);
                    if (o_result.point_offset_ns != w.point_offset_ns)
                        report_mismatch("point_offset_ns", 64'(o_result.point_offset_ns),
                                        64'(w.point_offset_ns));
                    if (o_result.out_payload != w.out_payload)
                        report_mismatch("out_payload", o_result.out_payload, w.out_payload);
                    if (o_result.frame_interval_100ns != w.frame_interval_100ns)
                        report_mismatch("frame_interval_100ns",
                                        64'(o_result.frame_interval_100ns),
                                        64'(w.frame_interval_100ns));
                    if (o_result.frame_point_count != w.frame_point_count)
                        report_mismatch("frame_point_count", 64'(o_result.frame_point_count),
                                        64'(w.frame_point_count));
                end
            end
            if (hold_off_cycles != 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                pop <= 1'b0;
            end else if (draining) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    // Push stays high after an accepted beat; a gap or an idle wait lowers it.
    task automatic send_item(input lpfw_pkg::t_item it);
        int unsigned gap;
        gap = random_gap();
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= it;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_frames(it);
        items_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // A dropped point leaves nothing pending, but the engine may still be busy.
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [31:0] value);
        wait_idle();
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        period_reg = value;
    endtask

    function automatic lpfw_pkg::t_item make_point(input logic [63:0] ts,
                                                   input logic [15:0] idx,
                                                   input logic [16:0] cnt,
                                                   input logic [31:0] iv);
        lpfw_pkg::t_item it;
        it.command = lpfw_pkg::CMD_POINT;
        it.pt_index = idx;
        it.batch_size = cnt;
        it.interval_100ns = iv;
        it.batch_timestamp_ns = ts;
        it.source_id = $urandom;
        it.batch_timestamp_raw = {$urandom, $urandom};
        it.point_payload = {$urandom, $urandom};
        return it;
    endfunction

    function automatic lpfw_pkg::t_item make_reset_cmd();
        lpfw_pkg::t_item it;
        it.command = lpfw_pkg::CMD_RESET;
        it.pt_index = 16'($urandom);
        it.batch_size = 17'($urandom);
        it.interval_100ns = $urandom;
        it.batch_timestamp_ns = {$urandom, $urandom};
        it.source_id = $urandom;
        it.batch_timestamp_raw = {$urandom, $urandom};
        it.point_payload = {$urandom, $urandom};
        return it;
    endfunction

    task automatic test_directed();
        send_item(make_reset_cmd());
        send_item(make_point(64'd1000, 16'd0, 17'd10, 32'd100));
        send_item(make_point(64'd1000, 16'd9, 17'd10, 32'd100));
        send_item(make_point(64'd1000, 16'd3, 17'd7, 32'd1));          // round to nearest
        send_item(make_point(64'd1000, 16'd5, 17'd1, 32'd500));        // short batch
        send_item(make_point(64'd1000, 16'd5, 17'd0, 32'd500));
        send_item(make_point(64'd1000, 16'd5, 17'd40, 32'd0));
        send_item(make_point(64'd1000, 16'hFFFF, 17'd3, 32'hFFFF_FFFF)); // index past count
        send_item(make_point(64'd1000, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF)); // oversized
        send_item(make_point(64'd1000, 16'hFFFF, 17'd65536, 32'd7));
        send_item(make_point(64'd500, 16'd0, 17'd2, 32'd1));           // time backward
        send_item(make_point(64'd500 + 64'd250_000_000, 16'd1, 17'd2, 32'd3)); // crossing
        send_item(make_point(U64_TOP, 16'd1, 17'd2, 32'd1));           // overflow
        send_item(make_point(U64_TOP - 64'd10, 16'd0, 17'd2, 32'd1));  // window end overflow
        send_item(make_reset_cmd());
        send_item(make_point(U64_TOP - 64'd10, 16'd0, 17'd2, 32'd1));  // open overflow
        send_item(make_point(64'h8000_0000_0000_0000, 16'd0, 17'd2, 32'd1));
        send_item(make_point(64'h8000_0000_0000_0000 + 64'h1_0000_0000, 16'd0, 17'd2, 32'd1));
        send_item(make_reset_cmd());
    endtask

    task automatic test_period_extremes();
        write_period(32'd0);
        send_item(make_point(64'd10, 16'd0, 17'd2, 32'd1));
        send_item(make_point(64'd12, 16'd1, 17'd2, 32'd1));
        send_item(make_point(64'd12, 16'd1, 17'd2, 32'd1));
        write_period(32'hFFFF_FFFF);
        send_item(make_point(64'd0, 16'd0, 17'd2, 32'd1));
        send_item(make_point(64'hFFFF_FFFF, 16'd0, 17'd2, 32'd1));
        send_item(make_point(U64_TOP - 64'hFFFF_FFFF, 16'd0, 17'd2, 32'd1));
        send_item(make_reset_cmd());
    endtask

    // Mostly rising streams of batches with random content, plus noise.
    task automatic test_random_streams(input int unsigned n, input logic [31:0] period);
        logic [63:0] ts;
        logic [16:0] cnt;
        logic [31:0] iv;
        int unsigned sel;
        write_period(period);
        ts = {$urandom, $urandom} >> $urandom_range(1, 40);
        for (int unsigned i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            cnt = $urandom_range(0, 99) < 90 ? 17'($urandom_range(0, 40)) : 17'($urandom);
            iv = $urandom_range(0, 99) < 80 ? 32'($urandom_range(0, 5000)) : 32'($urandom);
            if (sel < 80) begin
                ts = ts + 64'($urandom_range(0, 3 * period / 2 + 1));
                send_item(make_point(ts, 16'($urandom_range(0, 45)), cnt, iv));
            end else if (sel < 86) begin
                send_item(make_point(ts - 64'($urandom_range(1, 100000)), 16'($urandom),
                                     cnt, iv));
            end else if (sel < 90) begin
                send_item(make_reset_cmd());
            end else if (sel < 94) begin
                send_item(make_point(U64_TOP - 64'($urandom_range(0, 2000)), 16'($urandom),
                                     17'($urandom), $urandom));
            end else begin
                send_item(make_point({$urandom, $urandom}, 16'($urandom), 17'($urandom),
                                     $urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_item(make_point(64'd5000 + 64'(i * 10), 16'($urandom), 17'd8, 32'd3));
        wait_idle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        hold_off_cycles = 0;
        draining = 0;
        period_reg = lpfw_pkg::PERIOD_RESET;
        fr_active = 0; fr_win_start = 0; fr_win_end = 0; fr_first_time = 0;
        fr_open_raw = 0; fr_open_id = 0; fr_pending = 0; fr_last_off = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_period_extremes();
        test_backpressure();
        test_random_streams(250, 32'd1000);
        test_random_streams(200, 32'd1);
        test_random_streams(250, 32'd100000);
        test_random_streams(50, lpfw_pkg::PERIOD_RESET);

        draining = 1;
        wait_idle();
        $display("covered %0d items and %0d results over period settings 0, 1, 1e3, 1e5,",
                 items_sent, results_seen);
        $display("1e8 and 2^32-1, with reset commands, backward time and overflow");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
